[src/gwff_pkg.sv]
// Shared types and constants for the WLAN GeoNetworking frame filter.
// No dependencies; gwff_parse, gwff_outq and the top level import this package.
`timescale 1ns / 1ps

package gwff_pkg;

    localparam int unsigned CFG_INDEX_WIDTH = 1;
    localparam int unsigned CFG_DATA_WIDTH  = 16;
    localparam int unsigned CAP_WIDTH       = 16;
    localparam int unsigned HDR_WIDTH       = 6;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FILTER_ENABLE = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_CAPTURE   = 1'd1;

    localparam logic [HDR_WIDTH-1:0] HDR_BASE     = 6'd24;
    localparam logic [HDR_WIDTH-1:0] HDR_ADDR4    = 6'd6;
    localparam logic [HDR_WIDTH-1:0] HDR_QOS      = 6'd2;
    localparam logic [HDR_WIDTH-1:0] HDR_ORDER    = 6'd4;
    localparam logic [HDR_WIDTH-1:0] SNAP_LEN     = 6'd8;
    localparam logic [HDR_WIDTH-1:0] MIN_FRAME    = 6'd32;
    localparam logic [1:0]           TYPE_DATA    = 2'd2;

    typedef struct packed {
        logic                 filter_enable;
        logic [CAP_WIDTH-1:0] max_capture_length;
    } t_cfg;

    typedef struct packed {
        logic                 accept;
        logic [CAP_WIDTH-1:0] captured_length;
        logic                 truncated;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic       ready;
        logic [1:0] count;
    } t_queue_status;

    // LLC/SNAP header followed by the GeoNetworking EtherType
    function automatic logic [7:0] snap_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'haa;
            3'd1:    b = 8'haa;
            3'd2:    b = 8'h03;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h00;
            3'd5:    b = 8'h00;
            3'd6:    b = 8'h89;
            3'd7:    b = 8'h47;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[src/gwff_in_if.sv]
// Byte request channel into the frame filter.
// Depends on nothing.
`timescale 1ns / 1ps

interface gwff_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       is_last;
    logic       from_wlan;

    modport source (output valid, frame_byte, is_last, from_wlan, input ready);
    modport sink   (input valid, frame_byte, is_last, from_wlan, output ready);
endinterface

[src/gwff_out_if.sv]
// Verdict request channel out of the frame filter.
// Depends on nothing.
`timescale 1ns / 1ps

interface gwff_out_if;
    logic        valid;
    logic        ready;
    logic        accept;
    logic [15:0] captured_length;
    logic        truncated;

    modport source (output valid, accept, captured_length, truncated, input ready);
    modport sink   (input valid, accept, captured_length, truncated, output ready);
endinterface

[src/gwff_parse.sv]
// Per-frame parser: header length, SNAP match, byte count and verdict.
// Depends on gwff_pkg.
`timescale 1ns / 1ps

module gwff_parse
    import gwff_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_wlan,
    input  t_cfg       i_cfg,
    output logic       o_push,
    output t_result    o_result
);

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    logic [LENGTH_WIDTH-1:0] r_byte_count, n_byte_count;
    logic [15:0]             r_fc, n_fc;
    logic [HDR_WIDTH-1:0]    r_hdr, n_hdr;
    logic                    r_snap, n_snap;
    logic                    r_wlan, n_wlan;
    logic                    r_over, n_over;

    logic [LENGTH_WIDTH-1:0] pos, off, hdr_ext, win_end, min_ext;
    logic                    in_window, at_max;
    logic [CAP_WIDTH-1:0]    len16, limit, cap;
    logic                    too_long;

    always_comb begin
        pos     = r_byte_count;
        at_max  = (pos == LEN_MAX);
        n_fc    = r_fc;
        n_hdr   = r_hdr;
        n_wlan  = r_wlan;
        if (pos == '0) begin
            n_wlan = i_wlan;
            n_fc   = {8'h00, i_byte};
        end else if (pos == LENGTH_WIDTH'(1)) begin
            n_fc  = {i_byte, r_fc[7:0]};
            n_hdr = HDR_BASE
                  + ((n_fc[9:8] == 2'b11) ? HDR_ADDR4 : '0)
                  + (n_fc[7] ? HDR_QOS : '0)
                  + (n_fc[15] ? HDR_ORDER : '0);
        end

        hdr_ext   = LENGTH_WIDTH'(r_hdr);
        win_end   = LENGTH_WIDTH'(r_hdr + SNAP_LEN);
        off       = pos - hdr_ext;
        in_window = (pos >= hdr_ext) && (pos < win_end);
        n_snap    = r_snap && !(in_window && (i_byte != snap_byte(off[2:0])));

        n_byte_count = at_max ? pos : pos + LENGTH_WIDTH'(1);
        n_over       = r_over | at_max;

        // Clamp the limit: zero acts as one, and never beyond the counter range
        len16 = CAP_WIDTH'(n_byte_count);
        limit = (i_cfg.max_capture_length == '0) ? CAP_WIDTH'(1) : i_cfg.max_capture_length;
        if (limit > CAP_WIDTH'(LEN_MAX)) limit = CAP_WIDTH'(LEN_MAX);
        too_long = len16 > limit;
        cap      = too_long ? limit : len16;

        min_ext = LENGTH_WIDTH'(MIN_FRAME);
        o_push  = i_valid && i_last;
        o_result.captured_length = cap;
        o_result.truncated       = n_over || too_long;
        o_result.accept = !i_cfg.filter_enable
            || (n_wlan && (n_fc[3:2] == TYPE_DATA) && n_snap
                && (n_over || ((n_byte_count >= min_ext)
                    && (n_byte_count >= LENGTH_WIDTH'(n_hdr + SNAP_LEN)))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_fc         <= '0;
            r_hdr        <= HDR_BASE;
            r_snap       <= 1'b1;
            r_wlan       <= 1'b0;
            r_over       <= 1'b0;
        end else if (i_valid) begin
            if (i_last) begin
                // Return all per-frame state to idle
                r_byte_count <= '0;
                r_fc         <= '0;
                r_hdr        <= HDR_BASE;
                r_snap       <= 1'b1;
                r_wlan       <= 1'b0;
                r_over       <= 1'b0;
            end else begin
                r_byte_count <= n_byte_count;
                r_fc         <= n_fc;
                r_hdr        <= n_hdr;
                r_snap       <= n_snap;
                r_wlan       <= n_wlan;
                r_over       <= n_over;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_last) |=> (r_byte_count == '0 && r_snap && !r_over))
        else $error("frame state not cleared after last byte");

    a_hdr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_hdr[0] && r_hdr >= HDR_BASE && r_hdr <= HDR_BASE + 6'd12))
        else $error("header length out of range");

    a_over_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_over |-> (r_byte_count == LEN_MAX))
        else $error("overflow set below saturation");

endmodule

[src/gwff_outq.sv]
// Two-entry result queue that parts the parser from the output handshake.
// Depends on gwff_pkg.
`timescale 1ns / 1ps

module gwff_outq
    import gwff_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result       i_data,
    input  logic          i_pop,
    output t_result       o_data,
    output t_queue_status o_status
);

    t_result    r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
        o_data  = r_slot[r_rd_ptr];
        o_status.valid = (r_count != 2'd0);
        o_status.ready = (r_count != 2'd2);
        o_status.count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_count == 2'd2) |-> i_pop)
        else $error("push into full result queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("pop from empty result queue");

endmodule

[src/geonet_wifi_frame_filter.sv]
// Top level of the WLAN GeoNetworking frame filter.
// Depends on gwff_pkg, gwff_in_if, gwff_out_if, gwff_parse and gwff_outq.
`timescale 1ns / 1ps

// Takes one frame byte per clock and gives one verdict per frame, on its last byte:
// accept, captured length (clamped to max_capture_length) and truncated. A byte is
// registered on arrival and processed in the following cycle; the verdict is ready
// on the output channel in the cycle after that. A byte is accepted every cycle; the
// input stalls only when the two-entry result queue and the byte in flight would
// leave no room for a verdict. Configuration is written through i_cfg_we/i_cfg_index/
// i_cfg_wdata (index 0: filter_enable, index 1: max_capture_length); the user must
// write it only while no frame is in flight, as the block does not enforce this.
module geonet_wifi_frame_filter
    import gwff_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    gwff_in_if.sink                    i_in,
    gwff_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_wdata
);

    t_cfg          r_cfg;
    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_last;
    logic          r_in_wlan;
    logic          push;
    logic          pop;
    t_result       result;
    t_result       q_data;
    t_queue_status q_status;
    logic [1:0]    used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_enable      <= 1'b1;
            r_cfg.max_capture_length <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FILTER_ENABLE: r_cfg.filter_enable      <= i_cfg_wdata[0];
                CFG_MAX_CAPTURE:   r_cfg.max_capture_length <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Reserve a queue slot for a last byte still in the input register
    always_comb begin
        pop        = q_status.valid && o_out.ready;
        used       = q_status.count + {1'b0, r_in_valid && r_in_last} - {1'b0, pop};
        i_in.ready = (used < 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in.valid && i_in.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.frame_byte;
            r_in_last <= i_in.is_last;
            r_in_wlan <= i_in.from_wlan;
        end
    end

    gwff_parse #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_wlan   (r_in_wlan),
        .i_cfg    (r_cfg),
        .o_push   (push),
        .o_result (result)
    );

    gwff_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (result),
        .i_pop    (pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    assign o_out.valid           = q_status.valid;
    assign o_out.accept          = q_data.accept;
    assign o_out.captured_length = q_data.captured_length;
    assign o_out.truncated       = q_data.truncated;

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_status.ready || pop))
        else $error("verdict produced with no queue room");

endmodule
